FILE: design/acs_pkg.sv
// Shared types and constants for the accumulator stack CPU step unit.
// Used by acs_exec, acs_mem and accumulator_stack_cpu_step_unit.
`timescale 1ns / 1ps

package acs_pkg;

    // Default memory depth in 32-bit words
    localparam int MEM_WORDS_DEF = 65536;

    // Field widths
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int PLEN_W   = 17;
    localparam int LADDR_W  = 16;
    localparam int PADDR_W  = 3;

    // Configuration register word index (paddr[2])
    localparam logic REG_PLEN = 1'b0;

    // Step status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HALT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FAULT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PCRANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd4;

    // Opcodes
    localparam logic [7:0] OP_LDC  = 8'h00;
    localparam logic [7:0] OP_ADC  = 8'h01;
    localparam logic [7:0] OP_LDL  = 8'h02;
    localparam logic [7:0] OP_STL  = 8'h03;
    localparam logic [7:0] OP_LDNL = 8'h04;
    localparam logic [7:0] OP_STNL = 8'h05;
    localparam logic [7:0] OP_ADD  = 8'h06;
    localparam logic [7:0] OP_SUB  = 8'h07;
    localparam logic [7:0] OP_SHL  = 8'h08;
    localparam logic [7:0] OP_SHR  = 8'h09;
    localparam logic [7:0] OP_ADJ  = 8'h0A;
    localparam logic [7:0] OP_A2SP = 8'h0B;
    localparam logic [7:0] OP_SP2A = 8'h0C;
    localparam logic [7:0] OP_CALL = 8'h0D;
    localparam logic [7:0] OP_RET  = 8'h0E;
    localparam logic [7:0] OP_BRZ  = 8'h0F;
    localparam logic [7:0] OP_BRLZ = 8'h10;
    localparam logic [7:0] OP_BR   = 8'h11;
    localparam logic [7:0] OP_HALT = 8'h12;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    // Outcome of one step, from the execute logic to the sequencer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   pc;
        logic [DATA_W-1:0]   sp;
        logic [DATA_W-1:0]   a;
        logic [DATA_W-1:0]   b;
        logic                rd;     // data read needed
        logic                wr;     // data write needed
        logic [DATA_W-1:0]   addr;   // data address
        logic [DATA_W-1:0]   wdata;  // data to store
    } t_exec_res;

endpackage

FILE: design/acs_mem.sv
// Single-port synchronous word memory with registered read.
// Depends on acs_pkg for the word width.
`timescale 1ns / 1ps

module acs_mem #(
    parameter int DEPTH = acs_pkg::MEM_WORDS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_addr,
    input  logic [acs_pkg::DATA_W-1:0]  i_wdata,
    output logic [acs_pkg::DATA_W-1:0]  o_rdata
);

    logic [acs_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [acs_pkg::DATA_W-1:0] r_rdata;

    // Write or read, one access per cycle; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/acs_exec.sv
// Instruction decode and execute: range checks, ALU, branch and data address.
// Depends on acs_pkg for opcodes, status codes and t_exec_res.
`timescale 1ns / 1ps

module acs_exec #(
    parameter int MEM_WORDS = acs_pkg::MEM_WORDS_DEF
) (
    input  logic                        i_kind,
    input  logic [acs_pkg::DATA_W-1:0]  i_pc,
    input  logic [acs_pkg::DATA_W-1:0]  i_sp,
    input  logic [acs_pkg::DATA_W-1:0]  i_a,
    input  logic [acs_pkg::DATA_W-1:0]  i_b,
    input  logic [acs_pkg::PLEN_W-1:0]  i_plen,
    input  logic [acs_pkg::DATA_W-1:0]  i_inst,
    input  logic [acs_pkg::DATA_W-1:0]  i_data,
    output acs_pkg::t_exec_res          o_res
);

    localparam logic [acs_pkg::DATA_W-1:0] MEM_LIM = 32'(MEM_WORDS);

    logic [7:0]                 opc;
    logic [acs_pkg::DATA_W-1:0] opnd;
    logic [acs_pkg::DATA_W-1:0] ad_sp;
    logic [acs_pkg::DATA_W-1:0] ad_a;
    logic [acs_pkg::DATA_W-1:0] plen32;
    logic [acs_pkg::DATA_W-1:0] na, nb, nsp, npc, pc_inc;
    logic [acs_pkg::DATA_W-1:0] addr;
    logic                       fault, halt, rd, wr;

    assign opc    = i_inst[7:0];
    assign opnd   = {{8{i_inst[31]}}, i_inst[31:8]};
    assign ad_sp  = i_sp + opnd;
    assign ad_a   = i_a + opnd;
    assign plen32 = {{(acs_pkg::DATA_W-acs_pkg::PLEN_W){1'b0}}, i_plen};

    // Opcode execute
    always_comb begin
        na    = i_a;
        nb    = i_b;
        nsp   = i_sp;
        npc   = i_pc;
        addr  = ad_sp;
        fault = 1'b0;
        halt  = 1'b0;
        rd    = 1'b0;
        wr    = 1'b0;
        case (opc)
            acs_pkg::OP_LDC: begin
                nb = i_a;
                na = opnd;
            end
            acs_pkg::OP_ADC: na = i_a + opnd;
            acs_pkg::OP_LDL: begin
                fault = ad_sp[31] || (ad_sp >= MEM_LIM);
                rd    = 1'b1;
                nb    = i_a;
                na    = i_data;
            end
            acs_pkg::OP_STL: begin
                fault = ad_sp[31] || (ad_sp >= MEM_LIM);
                wr    = 1'b1;
                na    = i_b;
            end
            acs_pkg::OP_LDNL: begin
                addr  = ad_a;
                fault = ad_a[31] || (ad_a >= MEM_LIM);
                rd    = 1'b1;
                na    = i_data;
            end
            acs_pkg::OP_STNL: begin
                addr  = ad_a;
                fault = ad_a[31] || (ad_a >= MEM_LIM);
                wr    = 1'b1;
            end
            acs_pkg::OP_ADD: na = i_a + i_b;
            acs_pkg::OP_SUB: na = i_b - i_a;
            acs_pkg::OP_SHL: na = i_b << i_a[4:0];
            acs_pkg::OP_SHR: na = $unsigned($signed(i_b) >>> i_a[4:0]);
            acs_pkg::OP_ADJ: begin
                fault = ad_sp[31] || (ad_sp > MEM_LIM);
                nsp   = ad_sp;
            end
            acs_pkg::OP_A2SP: begin
                fault = i_a[31] || (i_a > MEM_LIM);
                nsp   = i_a;
                na    = i_b;
            end
            acs_pkg::OP_SP2A: begin
                nb = i_a;
                na = i_sp;
            end
            acs_pkg::OP_CALL: begin
                nb  = i_a;
                na  = i_pc;
                npc = i_pc + opnd;
            end
            acs_pkg::OP_RET: begin
                npc = i_a;
                na  = i_b;
            end
            acs_pkg::OP_BRZ:  if (i_a == '0) npc = i_pc + opnd;
            acs_pkg::OP_BRLZ: if (i_a[31]) npc = i_pc + opnd;
            acs_pkg::OP_BR:   npc = i_pc + opnd;
            acs_pkg::OP_HALT: halt = 1'b1;
            default: ;
        endcase
    end

    assign pc_inc = npc + 32'd1;

    // Step outcome: checks in priority order, then commit
    always_comb begin
        o_res        = '0;
        o_res.status = acs_pkg::ST_OK;
        o_res.pc     = i_pc;
        o_res.sp     = i_sp;
        o_res.a      = i_a;
        o_res.b      = i_b;
        o_res.addr   = addr;
        o_res.wdata  = (opc == acs_pkg::OP_STL) ? i_a : i_b;
        if (!i_kind) begin
            o_res.status = acs_pkg::ST_OK;
        end else if (i_pc[31] || (i_pc >= plen32)) begin
            o_res.status = acs_pkg::ST_DONE;
        end else if (i_pc >= MEM_LIM) begin
            o_res.status = acs_pkg::ST_FAULT;
        end else if (halt) begin
            o_res.status = acs_pkg::ST_HALT;
        end else if (fault) begin
            o_res.status = acs_pkg::ST_FAULT;
        end else begin
            o_res.pc     = pc_inc;
            o_res.sp     = nsp;
            o_res.a      = na;
            o_res.b      = nb;
            o_res.rd     = rd;
            o_res.wr     = wr;
            o_res.status = (pc_inc[31] || (pc_inc > plen32)) ?
                           acs_pkg::ST_PCRANGE : acs_pkg::ST_OK;
        end
    end

endmodule

FILE: design/accumulator_stack_cpu_step_unit.sv
// Accumulator stack CPU step unit: load or execute one item per beat.
// Result: registered from EXEC, or from LOAD for ldl and ldnl that read memory.
// Throughput: one item per cycle unless the output stalls; stl, stnl, ldl and ldnl
//   that pass the address check use the single memory port, blocking new items meanwhile.
// Reset: PC, SP, A, B and program_length clear; memory is not cleared.
// Depends on acs_pkg, acs_mem and acs_exec.
`timescale 1ns / 1ps

module accumulator_stack_cpu_step_unit #(
    parameter int MEM_WORDS = acs_pkg::MEM_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acs_pkg::PADDR_W-1:0]   paddr,
    input  logic [acs_pkg::DATA_W-1:0]    pwdata,
    output logic [acs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // item input
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_kind,
    input  logic [acs_pkg::LADDR_W-1:0]   i_address,
    input  logic [acs_pkg::DATA_W-1:0]    i_word,
    // result output
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [acs_pkg::STATUS_W-1:0]  o_status,
    output logic [acs_pkg::DATA_W-1:0]    o_pc,
    output logic [acs_pkg::DATA_W-1:0]    o_sp_out,
    output logic [acs_pkg::DATA_W-1:0]    o_reg_a_out,
    output logic [acs_pkg::DATA_W-1:0]    o_reg_b_out
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [acs_pkg::DATA_W-1:0] MEM_LIM = 32'(MEM_WORDS);

    acs_pkg::t_state r_state, n_state;
    acs_pkg::t_exec_res res;

    logic [acs_pkg::PLEN_W-1:0]   r_plen;
    logic [acs_pkg::DATA_W-1:0]   r_pc, r_sp, r_a, r_b;
    logic [acs_pkg::DATA_W-1:0]   n_pc, n_sp, n_a, n_b;
    logic                         r_kind;
    logic [acs_pkg::DATA_W-1:0]   r_inst;
    logic                         r_ovalid;
    logic [acs_pkg::STATUS_W-1:0] r_status;
    logic [acs_pkg::DATA_W-1:0]   r_opc, r_osp, r_oa, r_ob;

    logic                         can_emit, ready, in_acc, fin, data_acc;
    logic [acs_pkg::DATA_W-1:0]   exec_inst;
    logic [acs_pkg::DATA_W-1:0]   ld_addr32;
    logic                         mem_en, mem_we;
    logic [AW-1:0]                mem_addr;
    logic [acs_pkg::DATA_W-1:0]   mem_wdata, mem_rdata;

    // Config register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == acs_pkg::REG_PLEN) ?
                    {{(acs_pkg::DATA_W-acs_pkg::PLEN_W){1'b0}}, r_plen} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == acs_pkg::REG_PLEN)) begin
            r_plen <= pwdata[acs_pkg::PLEN_W-1:0];
        end
    end

    // Execute logic; in LOAD the fetched instruction comes from r_inst
    assign exec_inst = (r_state == acs_pkg::S_LOAD) ? r_inst : mem_rdata;

    acs_exec #(
        .MEM_WORDS(MEM_WORDS)
    ) u_exec (
        .i_kind (r_kind),
        .i_pc   (r_pc),
        .i_sp   (r_sp),
        .i_a    (r_a),
        .i_b    (r_b),
        .i_plen (r_plen),
        .i_inst (exec_inst),
        .i_data (mem_rdata),
        .o_res  (res)
    );

    // Handshake and step control
    assign can_emit = !r_ovalid || !i_stall;
    assign data_acc = (r_state == acs_pkg::S_EXEC) && (res.rd || res.wr);
    assign fin      = ((r_state == acs_pkg::S_EXEC) && !res.rd && can_emit) ||
                      ((r_state == acs_pkg::S_LOAD) && can_emit);
    assign ready    = (r_state == acs_pkg::S_IDLE) ||
                      ((r_state == acs_pkg::S_EXEC) && !res.rd && !res.wr && can_emit) ||
                      ((r_state == acs_pkg::S_LOAD) && can_emit);
    assign o_stall  = !ready;
    assign in_acc   = i_valid && ready;

    // Architectural registers as seen by the next fetch
    assign n_pc = fin ? res.pc : r_pc;
    assign n_sp = fin ? res.sp : r_sp;
    assign n_a  = fin ? res.a  : r_a;
    assign n_b  = fin ? res.b  : r_b;

    // Memory port: data access of the running step, else the new beat
    assign ld_addr32 = {{(acs_pkg::DATA_W-acs_pkg::LADDR_W){1'b0}}, i_address};

    always_comb begin
        if (data_acc) begin
            mem_en    = res.rd || can_emit;
            mem_we    = res.wr;
            mem_addr  = res.addr[AW-1:0];
            mem_wdata = res.wdata;
        end else begin
            mem_en    = in_acc && (i_kind || (ld_addr32 < MEM_LIM));
            mem_we    = !i_kind;
            mem_addr  = i_kind ? n_pc[AW-1:0] : ld_addr32[AW-1:0];
            mem_wdata = i_word;
        end
    end

    acs_mem #(
        .DEPTH(MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            acs_pkg::S_IDLE: begin
                if (in_acc) n_state = acs_pkg::S_EXEC;
            end
            acs_pkg::S_EXEC: begin
                if (res.rd) begin
                    n_state = acs_pkg::S_LOAD;
                end else if (can_emit) begin
                    n_state = in_acc ? acs_pkg::S_EXEC : acs_pkg::S_IDLE;
                end
            end
            acs_pkg::S_LOAD: begin
                if (can_emit) n_state = in_acc ? acs_pkg::S_EXEC : acs_pkg::S_IDLE;
            end
            default: n_state = acs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acs_pkg::S_IDLE;
            r_pc    <= '0;
            r_sp    <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_kind  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_sp    <= n_sp;
            r_a     <= n_a;
            r_b     <= n_b;
            if (in_acc) r_kind <= i_kind;
        end
    end

    // Hold the instruction while its data read is in flight
    always_ff @(posedge i_clk) begin
        if ((r_state == acs_pkg::S_EXEC) && res.rd) r_inst <= mem_rdata;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fin) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_status <= res.status;
            r_opc    <= res.pc;
            r_osp    <= res.sp;
            r_oa     <= res.a;
            r_ob     <= res.b;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_status    = r_status;
    assign o_pc        = r_opc;
    assign o_sp_out    = r_osp;
    assign o_reg_a_out = r_oa;
    assign o_reg_b_out = r_ob;

    // Checks
    a_no_store_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(data_acc && in_acc))
        else $error("new beat accepted during a data access");

    a_fin_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> o_valid)
        else $error("finished step not presented");

    a_halt_keeps_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && (res.status == acs_pkg::ST_HALT)) |=> (r_pc == $past(r_pc)))
        else $error("halt moved the pc");

    a_load_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == acs_pkg::S_LOAD) |->
        ($past(r_state) == acs_pkg::S_EXEC || $past(r_state) == acs_pkg::S_LOAD))
        else $error("data read state entered without execute");

    a_no_result_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |-> !fin)
        else $error("result overwritten while stalled");

endmodule
